### rtl/page_frame_bitmap_allocator_defines.svh
// Assertion macros for the page frame allocator.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define PFBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PFBA_CHECK(label, cond, msg) \
	`PFBA_ASSERT(label, (cond), msg)
`else
`define PFBA_ASSERT(label, prop, msg)
`define PFBA_CHECK(label, cond, msg)
`endif
`endif

### rtl/pfba_pkg.sv
package pfba_pkg;
	localparam int MAX_FRAMES  = 65536;
	localparam int MAX_REGIONS = 16;
	localparam int PAGE_BYTES  = 4096;
	localparam int ADDR_W      = 48;
	localparam int PAGE_W      = 37;
	localparam int CNT_W       = 17;
	localparam int WORD_BITS   = 32;
	localparam int WORD_LSB    = $clog2(WORD_BITS);
	localparam int NWORDS      = MAX_FRAMES / WORD_BITS;
	localparam int WIDX_W      = $clog2(NWORDS);
	localparam int FIDX_W      = $clog2(MAX_FRAMES) + 1;
	localparam int RIDX_W      = $clog2(MAX_REGIONS);
	localparam int RCNT_W      = $clog2(MAX_REGIONS + 1);
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int OFF_W       = PAGE_W + RIDX_W + 1;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_QUERY   = 2'd2,
		MODE_REGION  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_NOT_READY = 3'd1,
		STS_INVALID   = 3'd2,
		STS_OOM       = 3'd3,
		STS_UNAVAIL   = 3'd4,
		STS_NOT_ALLOC = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		FS_FREE     = 2'd0,
		FS_ALLOC    = 2'd1,
		FS_RESERVED = 2'd2,
		FS_UNAVAIL  = 2'd3
	} fstate_t;

	typedef enum logic [6:0] {
		S_CLEAR   = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_SCAN_RD = 7'b0000100,
		S_SCAN_EV = 7'b0001000,
		S_WALK    = 7'b0010000,
		S_BIT_CHK = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;
endpackage

### rtl/page_frame_bitmap_allocator.sv
// Channel | Handshake          | Words carried
// input   | in_valid/in_stall  | mode, address, region_slot, region_base_page,
//         |                    | region_end_page, region_kind
// output  | out_valid/out_stall| status, frame_address, frame_state, free_pages,
//         |                    | allocated_pages
// config  | cfg_wr_en          | cfg_wr_data (regions_in_use)
// Allocation reads and evaluates each bitmap word scanned (S_SCAN_RD, S_SCAN_EV), then walks region entries.
// Release and query walk the region entries, then may check the frame's bit; region writes go straight to S_DONE.
// The bitmap lives in a 32-bit-wide memory; one word is read each cycle.
// After reset and after every configuration write a clearing pass runs over every bitmap word,
// during which no input word is accepted.
// A stalled output holds its word; the next input word is taken while it waits.
`include "page_frame_bitmap_allocator_defines.svh"
module page_frame_bitmap_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [4:0]                  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  mode,
	input  logic [pfba_pkg::ADDR_W-1:0] address,
	input  logic [3:0]                  region_slot,
	input  logic [pfba_pkg::PAGE_W-1:0] region_base_page,
	input  logic [pfba_pkg::PAGE_W-1:0] region_end_page,
	input  logic [1:0]                  region_kind,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  status,
	output logic [pfba_pkg::ADDR_W-1:0] frame_address,
	output logic [1:0]                  frame_state,
	output logic [pfba_pkg::CNT_W-1:0]  free_pages,
	output logic [pfba_pkg::CNT_W-1:0]  allocated_pages
);
	localparam int PG_IN_W = pfba_pkg::ADDR_W - pfba_pkg::PAGE_SHIFT;

	pfba_pkg::state_t st_q;
	logic [pfba_pkg::WORD_BITS-1:0] bitmap_mem [pfba_pkg::NWORDS];
	logic [pfba_pkg::WORD_BITS-1:0] rdata_q;
	logic [pfba_pkg::PAGE_W-1:0] rt_base_q [pfba_pkg::MAX_REGIONS];
	logic [pfba_pkg::PAGE_W-1:0] rt_end_q [pfba_pkg::MAX_REGIONS];
	logic [1:0] rt_kind_q [pfba_pkg::MAX_REGIONS];

	logic [pfba_pkg::RCNT_W-1:0] nreg_q, ri_q;
	logic [pfba_pkg::FIDX_W-1:0] usable_q, free_q, alloc_q, cursor_q, acc_q, idx_q, rem_q;
	logic [pfba_pkg::WIDX_W:0] clr_w_q;
	logic [pfba_pkg::WIDX_W-1:0] scan_w_q;
	logic first_q;
	logic [pfba_pkg::OFF_W-1:0] off_q;
	logic [pfba_pkg::PAGE_W-1:0] page_q;
	logic [pfba_pkg::WORD_BITS-1:0] word_q;
	pfba_pkg::mode_t mode_q;
	pfba_pkg::status_t res_sts_q;
	pfba_pkg::fstate_t res_fs_q;
	logic [pfba_pkg::ADDR_W-1:0] res_addr_q;

	logic out_valid_q;
	logic [2:0] status_q;
	logic [pfba_pkg::ADDR_W-1:0] faddr_q;
	logic [1:0] fs_q;
	logic [pfba_pkg::CNT_W-1:0] free_out_q, alloc_out_q;

	logic mem_we;
	logic [pfba_pkg::WIDX_W-1:0] mem_waddr, mem_raddr;
	logic [pfba_pkg::WORD_BITS-1:0] mem_wdata;

	logic [pfba_pkg::RIDX_W-1:0] rsel;
	logic [pfba_pkg::PAGE_W-1:0] e_base, e_end, e_pages;
	logic e_usable, walk_end, in_rng, a_hit, bit_set;
	logic [pfba_pkg::PAGE_W:0] acc_sum;
	logic [pfba_pkg::OFF_W:0] l_idx;
	logic [pfba_pkg::WORD_BITS-1:0] zmask;
	logic [pfba_pkg::WORD_LSB-1:0] zpos;
	logic zany;
	logic [pfba_pkg::FIDX_W-1:0] f_idx, next_w_base;
	logic [pfba_pkg::PAGE_W:0] a_sum;
	logic ready, accept;

	assign rsel     = ri_q[pfba_pkg::RIDX_W-1:0];
	assign e_base   = rt_base_q[rsel];
	assign e_end    = rt_end_q[rsel];
	assign e_usable = (rt_kind_q[rsel] == 2'd0);
	assign e_pages  = (e_end > e_base) ? (e_end - e_base) : '0;
	assign walk_end = (ri_q >= nreg_q);
	assign in_rng   = (page_q >= e_base) && (page_q < e_end);
	assign a_hit    = !walk_end && e_usable &&
		({{(pfba_pkg::PAGE_W-pfba_pkg::FIDX_W){1'b0}}, rem_q} < e_pages);
	assign acc_sum  = {1'b0, e_pages} + (pfba_pkg::PAGE_W+1)'(acc_q);
	assign l_idx    = (pfba_pkg::OFF_W+1)'(off_q) + (pfba_pkg::OFF_W+1)'(page_q - e_base);
	assign a_sum    = {1'b0, e_base} + (pfba_pkg::PAGE_W+1)'(rem_q);
	assign bit_set  = rdata_q[idx_q[pfba_pkg::WORD_LSB-1:0]];
	assign ready    = (nreg_q != '0);
	assign in_stall = (st_q != pfba_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		zmask = ~rdata_q;
		if (first_q) begin
			zmask = zmask & ({pfba_pkg::WORD_BITS{1'b1}} << cursor_q[pfba_pkg::WORD_LSB-1:0]);
		end
		zany = (zmask != '0);
		zpos = '0;
		for (int b = pfba_pkg::WORD_BITS - 1; b >= 0; b--) begin
			if (zmask[b]) begin
				zpos = pfba_pkg::WORD_LSB'(b);
			end
		end
	end
	assign f_idx       = {1'b0, scan_w_q, zpos};
	assign next_w_base = {scan_w_q, {pfba_pkg::WORD_LSB{1'b0}}} + pfba_pkg::FIDX_W'(pfba_pkg::WORD_BITS);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[pfba_pkg::FIDX_W-2:pfba_pkg::WORD_LSB];
		mem_wdata = word_q;
		mem_raddr = scan_w_q;
		case (st_q)
			pfba_pkg::S_CLEAR: begin
				mem_we    = (clr_w_q < (pfba_pkg::WIDX_W+1)'(pfba_pkg::NWORDS));
				mem_waddr = clr_w_q[pfba_pkg::WIDX_W-1:0];
				mem_wdata = '0;
			end
			pfba_pkg::S_WALK: begin
				mem_we    = (mode_q == pfba_pkg::MODE_ALLOC) && a_hit;
				mem_raddr = idx_q[pfba_pkg::FIDX_W-2:pfba_pkg::WORD_LSB];
				if (mode_q != pfba_pkg::MODE_ALLOC) begin
					mem_raddr = l_idx[pfba_pkg::FIDX_W-2:pfba_pkg::WORD_LSB];
				end
			end
			pfba_pkg::S_BIT_CHK: begin
				mem_we    = (mode_q == pfba_pkg::MODE_RELEASE) && bit_set;
				mem_wdata = rdata_q & ~(pfba_pkg::WORD_BITS'(1) << idx_q[pfba_pkg::WORD_LSB-1:0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= bitmap_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && (mode == pfba_pkg::MODE_REGION) && !ready) begin
			rt_base_q[region_slot[pfba_pkg::RIDX_W-1:0]] <= region_base_page;
			rt_end_q[region_slot[pfba_pkg::RIDX_W-1:0]]  <= region_end_page;
			rt_kind_q[region_slot[pfba_pkg::RIDX_W-1:0]] <= region_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= pfba_pkg::S_CLEAR;
			nreg_q      <= '0;
			ri_q        <= '0;
			clr_w_q     <= '0;
			acc_q       <= '0;
			usable_q    <= '0;
			free_q      <= '0;
			alloc_q     <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				pfba_pkg::S_CLEAR: begin
					if (clr_w_q < (pfba_pkg::WIDX_W+1)'(pfba_pkg::NWORDS)) begin
						clr_w_q <= clr_w_q + 1'b1;
					end
					if (!walk_end) begin
						ri_q <= ri_q + 1'b1;
						if (e_usable) begin
							acc_q <= (acc_sum > (pfba_pkg::PAGE_W+1)'(pfba_pkg::MAX_FRAMES)) ?
								pfba_pkg::FIDX_W'(pfba_pkg::MAX_FRAMES) : pfba_pkg::FIDX_W'(acc_sum);
						end
					end else if (clr_w_q == (pfba_pkg::WIDX_W+1)'(pfba_pkg::NWORDS)) begin
						usable_q <= acc_q;
						free_q   <= acc_q;
						alloc_q  <= '0;
						cursor_q <= '0;
						st_q     <= pfba_pkg::S_IDLE;
					end
				end
				pfba_pkg::S_IDLE: begin
					if (accept) begin
						mode_q     <= pfba_pkg::mode_t'(mode);
						page_q     <= pfba_pkg::PAGE_W'(address[pfba_pkg::ADDR_W-1:pfba_pkg::PAGE_SHIFT]);
						res_sts_q  <= pfba_pkg::STS_OK;
						res_fs_q   <= pfba_pkg::FS_FREE;
						res_addr_q <= '0;
						ri_q       <= '0;
						off_q      <= '0;
						scan_w_q   <= cursor_q[pfba_pkg::FIDX_W-2:pfba_pkg::WORD_LSB];
						first_q    <= 1'b1;
						st_q       <= pfba_pkg::S_DONE;
						if (mode == pfba_pkg::MODE_REGION) begin
							if (ready) begin
								res_sts_q <= pfba_pkg::STS_INVALID;
							end
						end else if (!ready) begin
							res_sts_q <= pfba_pkg::STS_NOT_READY;
						end else if (mode == pfba_pkg::MODE_ALLOC) begin
							if (free_q == '0) begin
								res_sts_q <= pfba_pkg::STS_OOM;
							end else if (cursor_q >= usable_q) begin
								res_sts_q <= pfba_pkg::STS_INVALID;
							end else begin
								st_q <= pfba_pkg::S_SCAN_RD;
							end
						end else if (address[pfba_pkg::PAGE_SHIFT-1:0] != '0) begin
							res_sts_q <= pfba_pkg::STS_INVALID;
						end else begin
							st_q <= pfba_pkg::S_WALK;
						end
					end
				end
				pfba_pkg::S_SCAN_RD: begin
					st_q <= pfba_pkg::S_SCAN_EV;
				end
				pfba_pkg::S_SCAN_EV: begin
					first_q <= 1'b0;
					if (zany) begin
						idx_q  <= f_idx;
						rem_q  <= f_idx;
						word_q <= rdata_q | (pfba_pkg::WORD_BITS'(1) << zpos);
						if (f_idx >= usable_q) begin
							res_sts_q <= pfba_pkg::STS_INVALID;
							st_q      <= pfba_pkg::S_DONE;
						end else begin
							st_q <= pfba_pkg::S_WALK;
						end
					end else begin
						scan_w_q <= scan_w_q + 1'b1;
						if (next_w_base >= usable_q) begin
							res_sts_q <= pfba_pkg::STS_INVALID;
							st_q      <= pfba_pkg::S_DONE;
						end else begin
							st_q <= pfba_pkg::S_SCAN_RD;
						end
					end
				end
				pfba_pkg::S_WALK: begin
					ri_q <= ri_q + 1'b1;
					if (mode_q == pfba_pkg::MODE_ALLOC) begin
						if (walk_end) begin
							res_sts_q <= pfba_pkg::STS_INVALID;
							st_q      <= pfba_pkg::S_DONE;
						end else if (a_hit) begin
							res_addr_q <= pfba_pkg::ADDR_W'({a_sum, {pfba_pkg::PAGE_SHIFT{1'b0}}});
							cursor_q   <= idx_q + 1'b1;
							free_q     <= free_q - 1'b1;
							alloc_q    <= alloc_q + 1'b1;
							st_q       <= pfba_pkg::S_DONE;
						end else if (e_usable) begin
							rem_q <= pfba_pkg::FIDX_W'({{(pfba_pkg::PAGE_W-pfba_pkg::FIDX_W){1'b0}}, rem_q} - e_pages);
						end
					end else begin
						if (walk_end) begin
							res_fs_q <= pfba_pkg::FS_UNAVAIL;
							if (mode_q == pfba_pkg::MODE_RELEASE) begin
								res_sts_q <= pfba_pkg::STS_UNAVAIL;
							end
							st_q     <= pfba_pkg::S_DONE;
						end else if (in_rng) begin
							st_q <= pfba_pkg::S_DONE;
							if (!e_usable) begin
								res_fs_q <= pfba_pkg::FS_RESERVED;
								if (mode_q == pfba_pkg::MODE_RELEASE) begin
									res_sts_q <= pfba_pkg::STS_UNAVAIL;
								end
							end else if (l_idx >= (pfba_pkg::OFF_W+1)'(usable_q)) begin
								res_fs_q <= pfba_pkg::FS_UNAVAIL;
								if (mode_q == pfba_pkg::MODE_RELEASE) begin
									res_sts_q <= pfba_pkg::STS_UNAVAIL;
								end
							end else begin
								idx_q <= pfba_pkg::FIDX_W'(l_idx);
								st_q  <= pfba_pkg::S_BIT_CHK;
							end
						end else if (e_usable) begin
							off_q <= off_q + pfba_pkg::OFF_W'(e_pages);
						end
					end
				end
				pfba_pkg::S_BIT_CHK: begin
					st_q     <= pfba_pkg::S_DONE;
					res_fs_q <= bit_set ? pfba_pkg::FS_ALLOC : pfba_pkg::FS_FREE;
					if (mode_q == pfba_pkg::MODE_RELEASE) begin
						if (bit_set) begin
							if (idx_q < cursor_q) begin
								cursor_q <= idx_q;
							end
							free_q <= free_q + 1'b1;
							if (alloc_q != '0) begin
								alloc_q <= alloc_q - 1'b1;
							end
						end else begin
							res_sts_q <= pfba_pkg::STS_NOT_ALLOC;
						end
					end
				end
				pfba_pkg::S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						st_q        <= pfba_pkg::S_IDLE;
					end
				end
				default: begin
					st_q <= pfba_pkg::S_IDLE;
				end
			endcase
			if (cfg_wr_en) begin
				nreg_q  <= (cfg_wr_data > 5'(pfba_pkg::MAX_REGIONS)) ?
					pfba_pkg::RCNT_W'(pfba_pkg::MAX_REGIONS) : pfba_pkg::RCNT_W'(cfg_wr_data);
				ri_q    <= '0;
				clr_w_q <= '0;
				acc_q   <= '0;
				st_q    <= pfba_pkg::S_CLEAR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == pfba_pkg::S_DONE) && (!out_valid_q || !out_stall)) begin
			status_q    <= res_sts_q;
			faddr_q     <= res_addr_q;
			fs_q        <= (mode_q == pfba_pkg::MODE_QUERY && res_sts_q == pfba_pkg::STS_OK) ?
				res_fs_q : pfba_pkg::FS_FREE;
			free_out_q  <= pfba_pkg::CNT_W'(free_q);
			alloc_out_q <= pfba_pkg::CNT_W'(alloc_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign frame_address   = faddr_q;
	assign frame_state     = fs_q;
	assign free_pages      = free_out_q;
	assign allocated_pages = alloc_out_q;

	`PFBA_CHECK(a_count_sum, (st_q == pfba_pkg::S_IDLE) |-> ((pfba_pkg::FIDX_W+1)'(free_q) + (pfba_pkg::FIDX_W+1)'(alloc_q) == (pfba_pkg::FIDX_W+1)'(usable_q)), "free and allocated counts do not add up")
	`PFBA_CHECK(a_cursor_range, (st_q == pfba_pkg::S_IDLE) |-> (cursor_q <= usable_q), "search cursor beyond usable frames")
	`PFBA_CHECK(a_accept_busy, (accept && !cfg_wr_en) |=> (st_q != pfba_pkg::S_IDLE), "accepted word left the block idle")
	`PFBA_CHECK(a_write_state, mem_we |-> (st_q == pfba_pkg::S_CLEAR || st_q == pfba_pkg::S_WALK || st_q == pfba_pkg::S_BIT_CHK), "bitmap written outside an update")
endmodule

### tb/page_frame_bitmap_allocator_test.sv
`timescale 1ns / 100ps

module page_frame_bitmap_allocator_test;
	localparam int LIMIT_CYCLES = 1500000;

	typedef struct {
		pfba_pkg::mode_t mode;
		logic [47:0] addr;
		logic [3:0]  slot;
		logic [36:0] base;
		logic [36:0] top;
		logic [1:0]  kind;
	} frame_word_t;

	typedef struct {
		pfba_pkg::status_t status;
		logic [47:0] faddr;
		pfba_pkg::fstate_t fstate;
		logic [16:0] free_n;
		logic [16:0] used_n;
	} frame_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [4:0] cfg_wr_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] mode = 0;
	logic [47:0] address = 0;
	logic [3:0] region_slot = 0;
	logic [36:0] region_base_page = 0;
	logic [36:0] region_end_page = 0;
	logic [1:0] region_kind = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic [47:0] frame_address;
	logic [1:0] frame_state;
	logic [16:0] free_pages;
	logic [16:0] allocated_pages;

	page_frame_bitmap_allocator dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .address(address),
		.region_slot(region_slot), .region_base_page(region_base_page),
		.region_end_page(region_end_page), .region_kind(region_kind),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.frame_address(frame_address), .frame_state(frame_state),
		.free_pages(free_pages), .allocated_pages(allocated_pages)
	);

	always #10 clk = ~clk;

	frame_word_t pending_words[$];
	frame_result_t expected_results[$];
	frame_word_t word_now;
	int errors = 0;
	int cycles = 0;
	bit calm = 0;
	bit hold_armed = 0;
	bit hold_done = 0;
	int hold_left = 0;

	// Shadow copy of the allocator.
	bit frame_used[pfba_pkg::MAX_FRAMES];
	logic [36:0] reg_base[pfba_pkg::MAX_REGIONS];
	logic [36:0] reg_top[pfba_pkg::MAX_REGIONS];
	logic [1:0] reg_kind[pfba_pkg::MAX_REGIONS];
	bit reg_written[pfba_pkg::MAX_REGIONS];
	int unsigned active_regions = 0;
	longint unsigned cursor = 0, usable = 0, free_cnt = 0, used_cnt = 0;

	function automatic longint unsigned span_of(int i);
		return (reg_top[i] > reg_base[i]) ? longint'(reg_top[i]) - longint'(reg_base[i]) : 0;
	endfunction

	function automatic void rebuild_frames();
		longint unsigned total;
		total = 0;
		for (int i = 0; i < pfba_pkg::MAX_FRAMES; i++) frame_used[i] = 0;
		for (int i = 0; i < active_regions; i++)
			if (reg_kind[i] == 0) total += span_of(i);
		if (total > pfba_pkg::MAX_FRAMES) total = pfba_pkg::MAX_FRAMES;
		usable = total;
		free_cnt = total;
		used_cnt = 0;
		cursor = 0;
	endfunction

	function automatic frame_result_t predict_frame_op(frame_word_t w);
		frame_result_t r;
		longint unsigned idx, rem, page, off;
		bit found, done;
		pfba_pkg::fstate_t fs;
		r.status = pfba_pkg::STS_OK;
		r.faddr = 0;
		r.fstate = pfba_pkg::FS_FREE;
		if (w.mode == pfba_pkg::MODE_REGION) begin
			if (active_regions != 0) begin
				r.status = pfba_pkg::STS_INVALID;
			end else begin
				reg_base[w.slot] = w.base;
				reg_top[w.slot] = w.top;
				reg_kind[w.slot] = w.kind;
				reg_written[w.slot] = 1;
			end
		end else if (active_regions == 0) begin
			r.status = pfba_pkg::STS_NOT_READY;
		end else if (w.mode == pfba_pkg::MODE_ALLOC) begin
			if (free_cnt == 0) begin
				r.status = pfba_pkg::STS_OOM;
			end else begin
				idx = cursor;
				while (idx < usable && frame_used[idx]) idx++;
				r.status = pfba_pkg::STS_INVALID;
				if (idx < usable) begin
					rem = idx;
					done = 0;
					for (int i = 0; i < active_regions && !done; i++) begin
						if (reg_kind[i] == 0) begin
							if (rem >= span_of(i)) begin
								rem -= span_of(i);
							end else begin
								r.faddr = 48'((longint'(reg_base[i]) + rem) * pfba_pkg::PAGE_BYTES);
								frame_used[idx] = 1;
								cursor = idx + 1;
								free_cnt--;
								used_cnt++;
								r.status = pfba_pkg::STS_OK;
								done = 1;
							end
						end
					end
				end
			end
		end else if (w.addr[11:0] != 0) begin
			r.status = pfba_pkg::STS_INVALID;
		end else begin
			page = w.addr >> 12;
			found = 0;
			done = 0;
			fs = pfba_pkg::FS_UNAVAIL;
			off = 0;
			idx = 0;
			for (int i = 0; i < active_regions && !done; i++) begin
				if (page >= reg_base[i] && page < reg_top[i]) begin
					done = 1;
					if (reg_kind[i] != 0) begin
						fs = pfba_pkg::FS_RESERVED;
					end else begin
						idx = off + page - reg_base[i];
						if (idx < usable) begin
							found = 1;
							fs = frame_used[idx] ? pfba_pkg::FS_ALLOC : pfba_pkg::FS_FREE;
						end
					end
				end else if (reg_kind[i] == 0) begin
					off += span_of(i);
				end
			end
			if (w.mode == pfba_pkg::MODE_QUERY) begin
				r.fstate = fs;
			end else if (!found) begin
				r.status = pfba_pkg::STS_UNAVAIL;
			end else if (fs != pfba_pkg::FS_ALLOC) begin
				r.status = pfba_pkg::STS_NOT_ALLOC;
			end else begin
				frame_used[idx] = 0;
				if (idx < cursor) cursor = idx;
				free_cnt++;
				if (used_cnt != 0) used_cnt--;
			end
		end
		r.free_n = 17'(free_cnt);
		r.used_n = 17'(used_cnt);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_frame_op(word_now));
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
					word_now = pending_words.pop_front();
					in_valid <= 1;
					mode <= word_now.mode;
					address <= word_now.addr;
					region_slot <= word_now.slot;
					region_base_page <= word_now.base;
					region_end_page <= word_now.top;
					region_kind <= word_now.kind;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else if (hold_armed && !hold_done) begin
			hold_done <= 1;
			hold_left <= 400;
			out_stall <= 1;
		end else begin
			out_stall <= !calm && $urandom_range(99) < 14;
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	always @(posedge clk) begin
		frame_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word", status, 0);
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (frame_address !== e.faddr)
					report_mismatch("frame_address", frame_address, e.faddr);
				if (frame_state !== e.fstate)
					report_mismatch("frame_state", frame_state, e.fstate);
				if (free_pages !== e.free_n) report_mismatch("free_pages", free_pages, e.free_n);
				if (allocated_pages !== e.used_n)
					report_mismatch("allocated_pages", allocated_pages, e.used_n);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("page_frame_bitmap_allocator test failed");
			$finish;
		end
	end

	task automatic send(pfba_pkg::mode_t m, logic [47:0] a, logic [3:0] s = 0,
			logic [36:0] b = 0, logic [36:0] t = 0, logic [1:0] k = 0);
		frame_word_t w;
		w.mode = m;
		w.addr = a;
		w.slot = s;
		w.base = b;
		w.top = t;
		w.kind = k;
		pending_words.push_back(w);
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_regions_in_use(logic [4:0] v);
		drain();
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		active_regions = (v > pfba_pkg::MAX_REGIONS) ? pfba_pkg::MAX_REGIONS : v;
		rebuild_frames();
	endtask

	function automatic logic [36:0] rand37();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [47:0] rand48();
		return {$urandom, $urandom};
	endfunction

	task automatic random_region(int slot);
		logic [36:0] b;
		logic [36:0] t;
		logic [1:0] k;
		int pick;
		k = ($urandom_range(99) < 75) ? 2'd0 : 2'($urandom_range(1, 3));
		b = ($urandom_range(99) < 70) ? 37'($urandom_range(0, 24'hFFFFFF)) : rand37();
		pick = $urandom_range(99);
		if (pick < 85) t = b + $urandom_range(1, 24);
		else if (pick < 95) t = b - $urandom_range(0, 5);
		else t = b + $urandom_range(100, 3000);
		send(pfba_pkg::MODE_REGION, rand48(), 4'(slot), b, t, k);
	endtask

	function automatic logic [47:0] page_in_regions(int n);
		int i;
		i = $urandom_range(0, n - 1);
		return 48'((longint'(reg_base[i]) + $urandom_range(0, 32'(span_of(i)) + 1)) << 12);
	endfunction

	initial begin
		int sent, n, ops, phase;
		logic [4:0] cfg_val;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		send(pfba_pkg::MODE_ALLOC, 48'h0);
		send(pfba_pkg::MODE_RELEASE, 48'h100000);
		send(pfba_pkg::MODE_QUERY, 48'hFFFF_FFFF_F000);
		send(pfba_pkg::MODE_REGION, 0, 4'd0, 37'h100, 37'h104, 2'd0);
		send(pfba_pkg::MODE_REGION, 0, 4'd1, 37'h200, 37'h210, 2'd2);
		send(pfba_pkg::MODE_REGION, 0, 4'd2, 37'h500, 37'h400, 2'd0);
		send(pfba_pkg::MODE_REGION, 0, 4'd3, 37'h300, 37'h302, 2'd0);
		send(pfba_pkg::MODE_REGION, 48'hFFFF_FFFF_FFFF, 4'd15, 37'h10_0000_0000,
			37'h1F_FFFF_FFFF, 2'd3);
		write_regions_in_use(5'd4);
		repeat (7) send(pfba_pkg::MODE_ALLOC, 0);
		send(pfba_pkg::MODE_QUERY, 48'h100000);
		send(pfba_pkg::MODE_QUERY, 48'h205000);
		send(pfba_pkg::MODE_QUERY, 48'h450000);
		send(pfba_pkg::MODE_QUERY, 48'hFFFF_FFFF_F000);
		send(pfba_pkg::MODE_QUERY, 48'h100FFF);
		send(pfba_pkg::MODE_RELEASE, 48'h102000);
		send(pfba_pkg::MODE_RELEASE, 48'h102000);
		send(pfba_pkg::MODE_RELEASE, 48'h203000);
		send(pfba_pkg::MODE_RELEASE, 48'h000001);
		send(pfba_pkg::MODE_ALLOC, 0);
		send(pfba_pkg::MODE_REGION, 0, 4'd5, 37'h1, 37'h2, 2'd1);
		sent = 28;

		// A single huge usable region fills the bitmap to capacity.
		write_regions_in_use(5'd0);
		send(pfba_pkg::MODE_REGION, 0, 4'd0, 37'h0, 37'h1F_FFFF_FFFF, 2'd0);
		write_regions_in_use(5'd1);
		repeat (5) send(pfba_pkg::MODE_ALLOC, 0);
		send(pfba_pkg::MODE_QUERY, 48'h0000_0FFF_F000);
		send(pfba_pkg::MODE_QUERY, 48'h0000_1000_0000);
		send(pfba_pkg::MODE_RELEASE, 48'h0000_1000_0000);
		send(pfba_pkg::MODE_RELEASE, 48'h0000_0000_1000);
		sent += 11;

		phase = 0;
		while (sent < 1800) begin
			write_regions_in_use(5'd0);
			case ($urandom_range(0, 5))
				0: n = 16;
				1: n = 17 + $urandom_range(0, 14);
				default: n = $urandom_range(1, 6);
			endcase
			for (int s = 0; s < ((n > 16) ? 16 : n); s++) random_region(s);
			repeat ($urandom_range(0, 3)) random_region($urandom_range(0, 15));
			sent += n;
			if (phase == 3 || phase == 4) cfg_val = 5'd31;
			else cfg_val = 5'(n);
			for (int s = 0; s < pfba_pkg::MAX_REGIONS; s++)
				if (!reg_written[s]) cfg_val = (cfg_val > s) ? 5'(s) : cfg_val;
			if (cfg_val == 0) cfg_val = 5'd1;
			write_regions_in_use(cfg_val);
			calm = (phase == 2);
			hold_armed = (phase == 1);
			ops = $urandom_range(80, 140);
			for (int j = 0; j < ops; j++) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7: send(pfba_pkg::MODE_ALLOC, rand48(), 4'($urandom),
						rand37(), rand37(), 2'($urandom));
					8, 9, 10, 11, 12: send(pfba_pkg::MODE_RELEASE, page_in_regions(active_regions));
					13, 14, 15, 16: send(pfba_pkg::MODE_QUERY, page_in_regions(active_regions));
					17: random_region($urandom_range(0, 15));
					18: send(pfba_pkg::mode_t'($urandom_range(1, 2)), rand48());
					default: send(pfba_pkg::mode_t'($urandom_range(1, 2)),
						page_in_regions(active_regions) | $urandom_range(1, 4095));
				endcase
			end
			sent += ops;
			drain();
			calm = 0;
			phase++;
		end

		drain();
		if (errors == 0) begin
			$display("page_frame_bitmap_allocator test passed");
		end else begin
			$display("page_frame_bitmap_allocator test failed");
		end
		$finish;
	end
endmodule
